// ===== hw/rtl/bfc_pkg.sv =====
package bfc_pkg;

  localparam int FRAMES_DEF   = 16;
  localparam int PIN_BITS_DEF = 16;

  localparam logic [1:0] ACT_FETCH     = 2'd0;
  localparam logic [1:0] ACT_UNPIN     = 2'd1;
  localparam logic [1:0] ACT_FLUSH_ONE = 2'd2;
  localparam logic [1:0] ACT_FLUSH_ALL = 2'd3;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_LOADED     = 3'd1;
  localparam logic [2:0] ST_ALL_PINNED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_DONE       = 3'd4;

  localparam logic [1:0] LOAD_NONE   = 2'd0;
  localparam logic [1:0] LOAD_READ   = 2'd1;
  localparam logic [1:0] LOAD_FORMAT = 2'd2;

  localparam logic [1:0] REG_DISK   = 2'd0;
  localparam logic [1:0] REG_LOG    = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  localparam logic [4:0] FRAMES_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FA_TEST,
    S_FA_EMIT
  } state_t;

endpackage

// ===== hw/rtl/bfc_ram.sv =====
module bfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/buffer_frame_table_clock_evict.sv =====
// Channel | Handshake                | Payload
// in      | in_valid / in_ready      | action, page_number, mark_dirty, sequential_hint
// out     | out_valid / out_ready    | status, frame_index, writeback_*, load_kind, log_flush, last
// cfg     | psel, penable, pwrite    | paddr, pwdata, prdata, pready
// Fetch, unpin and flush page scan the page and pin memories with one read per frame
// in use, then update the table in a decide state. Flush all tests each frame in use
// in turn and emits one result per writeback, or a single result if there is none.
// A request is taken only when the sequencer is idle; results wait in an output
// register, and the update step holds while that register is full and stalled.
// Synchronous active-low reset clears valid and dirty marks, pins are never used
// before a frame is loaded, so no clearing pass is needed.
module buffer_frame_table_clock_evict #(
  parameter int FRAMES   = bfc_pkg::FRAMES_DEF,
  parameter int PIN_BITS = bfc_pkg::PIN_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [31:0]               in_page_number,
  input  logic                      in_mark_dirty,
  input  logic                      in_sequential_hint,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [$clog2(FRAMES)-1:0] out_frame_index,
  output logic                      out_writeback_valid,
  output logic [31:0]               out_writeback_page,
  output logic [$clog2(FRAMES)-1:0] out_writeback_frame,
  output logic [1:0]                out_load_kind,
  output logic                      out_log_flush,
  output logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  bfc_pkg::state_t state_r, state_nxt;

  logic disk_r, log_r;
  logic [4:0] frames_r;

  logic [1:0]  act_r, act_nxt;
  logic [31:0] page_r, page_nxt;
  logic        mdirty_r, mdirty_nxt;
  logic        seq_r, seq_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [IW-1:0] start_r, start_nxt;

  logic                hit_r, hit_nxt;
  logic [IW-1:0]       hidx_r, hidx_nxt;
  logic [PIN_BITS-1:0] hpins_r, hpins_nxt;
  logic                hif_r, hif_nxt, lof_r, lof_nxt;
  logic [IW-1:0]       hiidx_r, hiidx_nxt, loidx_r, loidx_nxt;
  logic [31:0]         hipg_r, hipg_nxt, lopg_r, lopg_nxt;

  logic [FRAMES-1:0] valid_r, valid_nxt, dirty_r, dirty_nxt;
  logic [IW-1:0]     hand_r, hand_nxt;
  logic              first_r, first_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [IW-1:0]       fidx_r, fidx_nxt;
  logic                wbv_r, wbv_nxt;
  logic [31:0]         wbp_r, wbp_nxt;
  logic [IW-1:0]       wbf_r, wbf_nxt;
  logic [1:0]          load_r, load_nxt;
  logic                logf_r, logf_nxt;
  logic                last_r, last_nxt;

  logic [CW-1:0]       n;
  logic [FRAMES-1:0]   mask, fa_set;
  logic                re;
  logic [IW-1:0]       raddr;
  logic [31:0]         page_rd;
  logic [PIN_BITS-1:0] pins_rd;
  logic                page_we, pins_we;
  logic [IW-1:0]       page_wa, pins_wa;
  logic [31:0]         page_wd;
  logic [PIN_BITS-1:0] pins_wd;
  logic                out_free, cfg_wr;
  logic [IW-1:0]       v, ci;
  logic [31:0]         vpage;
  logic                wb, issue;
  logic [PIN_BITS-1:0] newp;
  logic [FRAMES-1:0]   onehot;

  bfc_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_page_ram (
    .clk(clk), .we(page_we), .waddr(page_wa), .wdata(page_wd),
    .re(re), .raddr(raddr), .rdata(page_rd)
  );

  bfc_ram #(.WIDTH(PIN_BITS), .DEPTH(FRAMES)) u_pins_ram (
    .clk(clk), .we(pins_we), .waddr(pins_wa), .wdata(pins_wd),
    .re(re), .raddr(raddr), .rdata(pins_rd)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_r   <= 1'b1;
      log_r    <= 1'b1;
      frames_r <= bfc_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bfc_pkg::REG_DISK:   disk_r   <= pwdata[0];
        bfc_pkg::REG_LOG:    log_r    <= pwdata[0];
        bfc_pkg::REG_FRAMES: frames_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bfc_pkg::REG_DISK:   prdata = {31'd0, disk_r};
      bfc_pkg::REG_LOG:    prdata = {31'd0, log_r};
      bfc_pkg::REG_FRAMES: prdata = {27'd0, frames_r};
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (frames_r == 5'd0) begin
      n = CW'(1);
    end else if (32'(frames_r) > 32'(FRAMES)) begin
      n = CW'(FRAMES);
    end else begin
      n = CW'(frames_r);
    end
    for (int i = 0; i < FRAMES; i++) begin
      mask[i] = (32'(i) < 32'(n));
    end
  end

  assign fa_set   = valid_r & dirty_r & mask;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == bfc_pkg::S_IDLE);
  assign ci       = cnt_r[IW-1:0];
  assign onehot   = FRAMES'(1) << ci;
  assign v        = hif_r ? hiidx_r : loidx_r;
  assign vpage    = hif_r ? hipg_r : lopg_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; page_nxt = page_r; mdirty_nxt = mdirty_r; seq_nxt = seq_r;
    cnt_nxt = cnt_r; pv_nxt = 1'b0; pidx_nxt = pidx_r; start_nxt = start_r;
    hit_nxt = hit_r; hidx_nxt = hidx_r; hpins_nxt = hpins_r;
    hif_nxt = hif_r; hiidx_nxt = hiidx_r; hipg_nxt = hipg_r;
    lof_nxt = lof_r; loidx_nxt = loidx_r; lopg_nxt = lopg_r;
    valid_nxt = valid_r; dirty_nxt = dirty_r; hand_nxt = hand_r; first_nxt = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt = status_r; fidx_nxt = fidx_r; wbv_nxt = wbv_r; wbp_nxt = wbp_r;
    wbf_nxt = wbf_r; load_nxt = load_r; logf_nxt = logf_r; last_nxt = last_r;
    re = 1'b0; raddr = ci;
    page_we = 1'b0; page_wa = v; page_wd = page_r;
    pins_we = 1'b0; pins_wa = hidx_r; pins_wd = hpins_r;
    wb = 1'b0; newp = hpins_r; issue = 1'b0;

    unique case (state_r)
      bfc_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action; page_nxt = in_page_number;
          mdirty_nxt = in_mark_dirty; seq_nxt = in_sequential_hint;
          cnt_nxt = '0; hit_nxt = 1'b0; hif_nxt = 1'b0; lof_nxt = 1'b0;
          first_nxt = 1'b1;
          start_nxt = (CW'(hand_r) < n) ? hand_r : '0;
          if (in_action == bfc_pkg::ACT_FLUSH_ALL) begin
            if (disk_r && (fa_set != '0)) begin
              state_nxt = bfc_pkg::S_FA_TEST;
            end else begin
              state_nxt = bfc_pkg::S_DECIDE;
            end
          end else begin
            state_nxt = bfc_pkg::S_SCAN;
          end
        end
      end
      bfc_pkg::S_SCAN: begin
        issue = (cnt_r < n);
        re = issue;
        pv_nxt = issue;
        pidx_nxt = ci;
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (pv_r) begin
          if (!hit_r && valid_r[pidx_r] && (page_rd == page_r)) begin
            hit_nxt = 1'b1; hidx_nxt = pidx_r; hpins_nxt = pins_rd;
          end
          if (!valid_r[pidx_r] || (pins_rd == '0)) begin
            if (pidx_r >= start_r) begin
              if (!hif_r) begin
                hif_nxt = 1'b1; hiidx_nxt = pidx_r; hipg_nxt = page_rd;
              end
            end else if (!lof_r) begin
              lof_nxt = 1'b1; loidx_nxt = pidx_r; lopg_nxt = page_rd;
            end
          end
        end
        if (!issue && !pv_r) begin
          state_nxt = bfc_pkg::S_DECIDE;
        end
      end
      bfc_pkg::S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt = bfc_pkg::ST_DONE; fidx_nxt = '0; wbv_nxt = 1'b0;
          wbp_nxt = '0; wbf_nxt = '0; load_nxt = bfc_pkg::LOAD_NONE;
          logf_nxt = 1'b0; last_nxt = 1'b1;
          state_nxt = bfc_pkg::S_IDLE;
          unique case (act_r)
            bfc_pkg::ACT_FETCH: begin
              if (hit_r) begin
                pins_we = 1'b1;
                pins_wd = (hpins_r == {PIN_BITS{1'b1}}) ? hpins_r : hpins_r + PIN_BITS'(1);
                status_nxt = bfc_pkg::ST_HIT;
                fidx_nxt = hidx_r;
              end else if (hif_r || lof_r) begin
                wb = valid_r[v] && dirty_r[v] && disk_r;
                hand_nxt = ((CW'(v) + CW'(1)) == n) ? '0 : v + IW'(1);
                valid_nxt[v] = 1'b1;
                dirty_nxt[v] = 1'b0;
                page_we = 1'b1;
                pins_we = 1'b1; pins_wa = v; pins_wd = PIN_BITS'(1);
                status_nxt = bfc_pkg::ST_LOADED;
                fidx_nxt = v;
                wbv_nxt = wb;
                wbp_nxt = wb ? vpage : '0;
                wbf_nxt = wb ? v : '0;
                load_nxt = disk_r ? bfc_pkg::LOAD_READ : bfc_pkg::LOAD_FORMAT;
                logf_nxt = wb && log_r;
              end else begin
                status_nxt = bfc_pkg::ST_ALL_PINNED;
              end
            end
            bfc_pkg::ACT_UNPIN: begin
              if (!hit_r) begin
                status_nxt = bfc_pkg::ST_NOT_FOUND;
              end else begin
                newp = (hpins_r == '0) ? '0 : hpins_r - PIN_BITS'(1);
                pins_we = 1'b1; pins_wd = newp;
                if (mdirty_r) begin
                  dirty_nxt[hidx_r] = 1'b1;
                end
                if ((newp == '0) && seq_r) begin
                  hand_nxt = hidx_r;
                end
                fidx_nxt = hidx_r;
              end
            end
            bfc_pkg::ACT_FLUSH_ONE: begin
              if (!hit_r) begin
                status_nxt = bfc_pkg::ST_NOT_FOUND;
              end else begin
                fidx_nxt = hidx_r;
                if (dirty_r[hidx_r] && disk_r) begin
                  dirty_nxt[hidx_r] = 1'b0;
                  wbv_nxt = 1'b1; wbp_nxt = page_r; wbf_nxt = hidx_r; logf_nxt = log_r;
                end
              end
            end
            bfc_pkg::ACT_FLUSH_ALL: begin
              logf_nxt = (fa_set != '0) && log_r;
            end
            default: ;
          endcase
        end
      end
      bfc_pkg::S_FA_TEST: begin
        if (cnt_r >= n) begin
          state_nxt = bfc_pkg::S_IDLE;
        end else if (fa_set[ci]) begin
          re = 1'b1;
          state_nxt = bfc_pkg::S_FA_EMIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      bfc_pkg::S_FA_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt = bfc_pkg::ST_DONE; fidx_nxt = ci; wbv_nxt = 1'b1;
          wbp_nxt = page_rd; wbf_nxt = ci; load_nxt = bfc_pkg::LOAD_NONE;
          logf_nxt = first_r && log_r;
          last_nxt = ((fa_set & ~onehot) == '0);
          dirty_nxt[ci] = 1'b0;
          first_nxt = 1'b0;
          cnt_nxt = cnt_r + CW'(1);
          state_nxt = last_nxt ? bfc_pkg::S_IDLE : bfc_pkg::S_FA_TEST;
        end
      end
      default: state_nxt = bfc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfc_pkg::S_IDLE;
      valid_r     <= '0;
      dirty_r     <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; page_r <= page_nxt; mdirty_r <= mdirty_nxt; seq_r <= seq_nxt;
    cnt_r <= cnt_nxt; pidx_r <= pidx_nxt; start_r <= start_nxt;
    hit_r <= hit_nxt; hidx_r <= hidx_nxt; hpins_r <= hpins_nxt;
    hif_r <= hif_nxt; hiidx_r <= hiidx_nxt; hipg_r <= hipg_nxt;
    lof_r <= lof_nxt; loidx_r <= loidx_nxt; lopg_r <= lopg_nxt;
    first_r <= first_nxt;
    status_r <= status_nxt; fidx_r <= fidx_nxt; wbv_r <= wbv_nxt; wbp_r <= wbp_nxt;
    wbf_r <= wbf_nxt; load_r <= load_nxt; logf_r <= logf_nxt; last_r <= last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_frame_index     = fidx_r;
  assign out_writeback_valid = wbv_r;
  assign out_writeback_page  = wbp_r;
  assign out_writeback_frame = wbf_r;
  assign out_load_kind       = load_r;
  assign out_log_flush       = logf_r;
  assign out_last            = last_r;

  a_loaded_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bfc_pkg::ST_LOADED) |-> valid_r[out_frame_index])
    else $error("loaded frame not marked valid");

  a_wb_disk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_writeback_valid |-> disk_r)
    else $error("writeback without disk");

  a_log_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_log_flush |-> log_r)
    else $error("log flush without log");

  a_wb_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_writeback_valid && (out_status == bfc_pkg::ST_DONE)
    |-> !dirty_r[out_writeback_frame])
    else $error("flushed frame still dirty");

endmodule

// ===== sim/buffer_frame_table_clock_evict_checker.sv =====
`timescale 1ns / 100ps

module buffer_frame_table_clock_evict_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_page_number,
  input  logic        in_mark_dirty,
  input  logic        in_sequential_hint,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_frame_index,
  input  logic        out_writeback_valid,
  input  logic [31:0] out_writeback_page,
  input  logic [3:0]  out_writeback_frame,
  input  logic [1:0]  out_load_kind,
  input  logic        out_log_flush,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam int NF = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        wb;
    logic [31:0] wpage;
    logic [3:0]  wframe;
    logic [1:0]  load;
    logic        logf;
    logic        last;
  } frame_result_t;

  frame_result_t expected_results[$];

  bit          slot_used [NF];
  logic [31:0] slot_page [NF];
  logic [15:0] slot_pins [NF];
  bit          slot_dirty[NF];
  int          victim_ptr;
  bit          disk_on;
  bit          log_on;
  logic [4:0]  frame_count;

  function automatic frame_result_t mk(logic [2:0] st, int fr, bit wb, logic [31:0] wp,
                                       int wf, logic [1:0] ld, bit lf, bit lst);
    frame_result_t r;
    r.status = st; r.frame = 4'(fr); r.wb = wb; r.wpage = wp; r.wframe = 4'(wf);
    r.load = ld; r.logf = lf; r.last = lst;
    return r;
  endfunction

  function automatic void predict_request(logic [1:0] act, logic [31:0] pg, bit md, bit sq);
    int n, f, start, v, k, lastd;
    bit found, has_dirty, wb;
    n = (frame_count == 0) ? 1 : (frame_count > NF) ? NF : frame_count;
    f = -1;
    if (act != bfc_pkg::ACT_FLUSH_ALL)
      for (int i = n - 1; i >= 0; i--)
        if (slot_used[i] && slot_page[i] == pg) f = i;
    case (act)
      bfc_pkg::ACT_FETCH: begin
        if (f >= 0) begin
          if (slot_pins[f] != 16'hFFFF) slot_pins[f]++;
          expected_results.push_back(mk(bfc_pkg::ST_HIT, f, 0, 0, 0, bfc_pkg::LOAD_NONE,
                                        0, 1));
        end else begin
          start = (victim_ptr < n) ? victim_ptr : 0;
          found = 0;
          v = 0;
          for (int i = 0; i < n && !found; i++) begin
            v = (start + i) % n;
            if (!slot_used[v] || slot_pins[v] == 0) found = 1;
          end
          if (!found) begin
            expected_results.push_back(mk(bfc_pkg::ST_ALL_PINNED, 0, 0, 0, 0,
                                          bfc_pkg::LOAD_NONE, 0, 1));
          end else begin
            victim_ptr = (v + 1) % n;
            wb = slot_used[v] && slot_dirty[v] && disk_on;
            expected_results.push_back(mk(bfc_pkg::ST_LOADED, v, wb, wb ? slot_page[v] : 0,
                                          wb ? v : 0,
                                          disk_on ? bfc_pkg::LOAD_READ : bfc_pkg::LOAD_FORMAT,
                                          wb && log_on, 1));
            slot_used[v] = 1;
            slot_page[v] = pg;
            slot_pins[v] = 1;
            slot_dirty[v] = 0;
          end
        end
      end
      bfc_pkg::ACT_UNPIN: begin
        if (f < 0) begin
          expected_results.push_back(mk(bfc_pkg::ST_NOT_FOUND, 0, 0, 0, 0,
                                        bfc_pkg::LOAD_NONE, 0, 1));
        end else begin
          if (slot_pins[f] != 0) slot_pins[f]--;
          if (md) slot_dirty[f] = 1;
          if (slot_pins[f] == 0 && sq) victim_ptr = f;
          expected_results.push_back(mk(bfc_pkg::ST_DONE, f, 0, 0, 0, bfc_pkg::LOAD_NONE,
                                        0, 1));
        end
      end
      bfc_pkg::ACT_FLUSH_ONE: begin
        if (f < 0) begin
          expected_results.push_back(mk(bfc_pkg::ST_NOT_FOUND, 0, 0, 0, 0,
                                        bfc_pkg::LOAD_NONE, 0, 1));
        end else if (slot_dirty[f] && disk_on) begin
          slot_dirty[f] = 0;
          expected_results.push_back(mk(bfc_pkg::ST_DONE, f, 1, slot_page[f], f,
                                        bfc_pkg::LOAD_NONE, log_on, 1));
        end else begin
          expected_results.push_back(mk(bfc_pkg::ST_DONE, f, 0, 0, 0, bfc_pkg::LOAD_NONE,
                                        0, 1));
        end
      end
      default: begin
        has_dirty = 0;
        lastd = 0;
        k = 0;
        for (int i = 0; i < n; i++)
          if (slot_used[i] && slot_dirty[i]) begin
            has_dirty = 1;
            lastd = i;
          end
        if (disk_on)
          for (int i = 0; i < n; i++)
            if (slot_used[i] && slot_dirty[i]) begin
              slot_dirty[i] = 0;
              expected_results.push_back(mk(bfc_pkg::ST_DONE, i, 1, slot_page[i], i,
                                            bfc_pkg::LOAD_NONE,
                                            (k == 0) && has_dirty && log_on, i == lastd));
              k++;
            end
        if (k == 0)
          expected_results.push_back(mk(bfc_pkg::ST_DONE, 0, 0, 0, 0, bfc_pkg::LOAD_NONE,
                                        has_dirty && log_on, 1));
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    frame_result_t e;
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < NF; i++) begin
        slot_used[i] = 0;
        slot_pins[i] = 0;
        slot_dirty[i] = 0;
      end
      victim_ptr = 0;
      disk_on = 1;
      log_on = 1;
      frame_count = bfc_pkg::FRAMES_RESET;
    end else begin
      if (psel && penable && pwrite && pready)
        case (paddr[3:2])
          bfc_pkg::REG_DISK:   disk_on = pwdata[0];
          bfc_pkg::REG_LOG:    log_on = pwdata[0];
          bfc_pkg::REG_FRAMES: frame_count = pwdata[4:0];
          default: ;
        endcase
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, out_status);
          check_field("frame_index", e.frame, out_frame_index);
          check_field("writeback_valid", e.wb, out_writeback_valid);
          check_field("writeback_page", e.wpage, out_writeback_page);
          check_field("writeback_frame", e.wframe, out_writeback_frame);
          check_field("load_kind", e.load, out_load_kind);
          check_field("log_flush", e.logf, out_log_flush);
          check_field("last", e.last, out_last);
        end
      end
      if (in_valid && in_ready)
        predict_request(in_action, in_page_number, in_mark_dirty, in_sequential_hint);
    end
    pending = expected_results.size();
  end

endmodule

// ===== sim/buffer_frame_table_clock_evict_test.sv =====
`timescale 1ns / 100ps

module buffer_frame_table_clock_evict_test;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_action = bfc_pkg::ACT_FETCH;
  logic [31:0] in_page_number = 0;
  logic        in_mark_dirty = 0;
  logic        in_sequential_hint = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status;
  logic [3:0]  out_frame_index;
  logic        out_writeback_valid;
  logic [31:0] out_writeback_page;
  logic [3:0]  out_writeback_frame;
  logic [1:0]  out_load_kind;
  logic        out_log_flush;
  logic        out_last;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  int          errors;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 0;
  logic [31:0] page_base = 32'h100;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  buffer_frame_table_clock_evict i_dut (.*);

  buffer_frame_table_clock_evict_checker i_checker (.*);

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      out_ready <= 0;
      repeat (400) @(negedge clk);
      hold_req = 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // drive one request starting at a falling edge; return after acceptance
  task automatic send_request(logic [1:0] act, logic [31:0] pg, bit md, bit sq);
    bit taken;
    in_valid <= 1;
    in_action <= act;
    in_page_number <= pg;
    in_mark_dirty <= md;
    in_sequential_hint <= sq;
    do begin
      #1 taken = in_ready;
      @(negedge clk);
    end while (!taken);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_page();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom;
    if (r == 1) return 32'hFFFF_FFFF;
    return page_base + $urandom_range(0, 19);
  endfunction

  task automatic random_requests(int count);
    int r;
    logic [1:0] act;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      act = (r < 40) ? bfc_pkg::ACT_FETCH : (r < 78) ? bfc_pkg::ACT_UNPIN :
            (r < 92) ? bfc_pkg::ACT_FLUSH_ONE : bfc_pkg::ACT_FLUSH_ALL;
      send_request(act, pick_page(), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    write_reg(bfc_pkg::REG_FRAMES, 2);
    @(negedge clk);
    send_request(bfc_pkg::ACT_FETCH, 32'h0, 0, 0);
    send_request(bfc_pkg::ACT_FETCH, 32'hFFFF_FFFF, 0, 0);
    send_request(bfc_pkg::ACT_FETCH, 32'h0, 0, 0);
    send_request(bfc_pkg::ACT_FETCH, 32'h5, 0, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h0, 1, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h0, 1, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h0, 0, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h7, 1, 1);
    send_request(bfc_pkg::ACT_UNPIN, 32'hFFFF_FFFF, 1, 1);
    send_request(bfc_pkg::ACT_FLUSH_ALL, 32'h0, 0, 0);
    send_request(bfc_pkg::ACT_FLUSH_ALL, 32'h0, 0, 0);
    send_request(bfc_pkg::ACT_FETCH, 32'h5, 0, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h5, 1, 0);
    send_request(bfc_pkg::ACT_FLUSH_ONE, 32'h5, 0, 0);
    send_request(bfc_pkg::ACT_FLUSH_ONE, 32'h9, 0, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h5, 1, 1);
    send_request(bfc_pkg::ACT_FETCH, 32'hAAAA_5555, 0, 0);
    send_request(bfc_pkg::ACT_FETCH, 32'h5555_AAAA, 0, 0);
    send_request(bfc_pkg::ACT_UNPIN, 32'h0, 1, 0);
    send_request(bfc_pkg::ACT_FLUSH_ONE, 32'h0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 78 : 0;
      recv_stall_pct = (ph < 2) ? 78 : (ph < 4) ? 37 : 0;
      page_base = $urandom;
      case (ph)
        0: begin
          write_reg(bfc_pkg::REG_DISK, 1); write_reg(bfc_pkg::REG_LOG, 1);
          write_reg(bfc_pkg::REG_FRAMES, 16);
        end
        1: begin
          write_reg(bfc_pkg::REG_DISK, 0); write_reg(bfc_pkg::REG_LOG, 1);
          write_reg(bfc_pkg::REG_FRAMES, 5);
        end
        2: begin
          write_reg(bfc_pkg::REG_DISK, 1); write_reg(bfc_pkg::REG_LOG, 0);
          write_reg(bfc_pkg::REG_FRAMES, 1);
        end
        3: begin
          write_reg(bfc_pkg::REG_DISK, 1); write_reg(bfc_pkg::REG_LOG, 1);
          write_reg(bfc_pkg::REG_FRAMES, 0);
        end
        4: begin
          write_reg(bfc_pkg::REG_DISK, 0); write_reg(bfc_pkg::REG_LOG, 0);
          write_reg(bfc_pkg::REG_FRAMES, 31);
        end
        default: begin
          write_reg(bfc_pkg::REG_DISK, 1); write_reg(bfc_pkg::REG_LOG, 1);
          write_reg(bfc_pkg::REG_FRAMES, 16);
        end
      endcase
      @(negedge clk);
      if (ph == 5) hold_req = 1;
      random_requests(75);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
